// File: rtl/assert_macros.svh
// Assertion macros shared by the hasher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

// File: rtl/sha_pkg.sv
// Types, constants and round functions shared by the hasher.
package sha_pkg;
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
	} out_item_t;

	// Queue entry between the front and the back: one byte and its kind.
	typedef struct packed {
		logic [7:0] data;
		logic       is_byte;
		logic       is_end;
	} q_entry_t;

	localparam int QDepth = 4;
	localparam int QAw = $clog2(QDepth);
	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenPos = 6'd56;

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction
endpackage

// File: rtl/sha256_stream_hasher.sv
// Top level of the streaming SHA-256 hasher.
// Usage:
// The input channel (in_valid, in_ready, in_item) carries one message byte per
// item; byte_valid marks a byte, end_of_message closes the message. Items with
// neither flag are taken and dropped. A four-entry queue separates the
// accepting front from the hashing back, so input can flow while the back works.
// The back takes items from the queue once they are stored there, one byte per
// cycle while it is in its take state; every 64th byte starts 64 rounds, after
// which the block is added into the chaining words.
// After end_of_message the back pads one byte per cycle to the block end and
// compresses one or two padded blocks before it offers the first digest item.
// The four digest items (out_valid, out_ready, out_item) follow at one per cycle
// while out_ready is high, most significant word first, last_word set on the
// fourth. If the receiver stalls, the digest item is held and the back stops;
// the queue then fills and in_ready drops. Reset loads the initial hash values
// and clears the queue.
module sha256_stream_hasher (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sha_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output sha_pkg::out_item_t out_item
);
	import sha_pkg::*;

	logic     q_valid, q_ready;
	q_entry_t q_entry;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_entry(q_entry)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_entry(q_entry), .out_valid(out_valid), .out_ready(out_ready),
		.out_item(out_item)
	);
endmodule

// File: rtl/sha_front.sv
// Front end: accepts items, drops empty ones and queues bytes and ends.
module sha_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sha_pkg::in_item_t  in_item,
	output logic               q_valid,
	input  logic               q_ready,
	output sha_pkg::q_entry_t  q_entry
);
	import sha_pkg::*;

	q_entry_t       mem_q [QDepth];
	logic [QAw-1:0] wr_q, rd_q;
	logic [QAw:0]   cnt_q;
	logic           push, pop;

	assign in_ready = (cnt_q != QDepth[QAw:0]);
	// An item with neither byte nor end is taken and dropped.
	assign push = in_valid && in_ready && (in_item.byte_valid || in_item.end_of_message);
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;
	assign q_entry = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {{QAw{1'b0}}, push} - {{QAw{1'b0}}, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= '{data: in_item.data_byte, is_byte: in_item.byte_valid,
			is_end: in_item.end_of_message};
	end

`include "assert_macros.svh"
	`ASSERT_IMPL(a_no_overflow, clk, arst_n, cnt_q == QDepth[QAw:0], !push)
	`ASSERT_NEXT(a_cnt_move, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
endmodule

// File: rtl/sha_core.sv
// Back end: block packing, padding, 64-round compression and digest output.
module sha_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  sha_pkg::q_entry_t  q_entry,
	output logic               out_valid,
	input  logic               out_ready,
	output sha_pkg::out_item_t out_item
);
	import sha_pkg::*;

	typedef enum logic [2:0] {S_TAKE, S_PAD, S_COMP, S_ADD, S_OUT} state_t;

	state_t      state_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [63:0] len_q;
	logic [5:0]  round_q;
	logic        ending_q;
	logic        closed_q;
	logic [1:0]  widx_q;
	logic        padded_q;
	logic        tail_q;

	logic        put;
	logic [7:0]  put_byte;
	logic [31:0] w_new, t1, t2, wcur;

	assign q_ready = (state_q == S_TAKE);
	assign out_valid = (state_q == S_OUT);
	assign out_item = '{digest_word: {h_q[{widx_q, 1'b0}], h_q[{widx_q, 1'b1}]},
		word_index: widx_q, last_word: (widx_q == 2'd3)};

	// Byte for the current fill position: a queued message byte while taking, else
	// the padding byte. The length only goes into the block that still had room for it after the 0x80 byte.
	always_comb begin
		put = 1'b0;
		put_byte = '0;
		if (state_q == S_TAKE && q_valid && q_entry.is_byte) begin
			put = 1'b1;
			put_byte = q_entry.data;
		end else if (state_q == S_PAD) begin
			put = 1'b1;
			if (!padded_q) put_byte = PadByte;
			else if (tail_q && fill_q >= LenPos) put_byte = len_q[8*(7-(fill_q-LenPos))+:8];
			else put_byte = '0;
		end
	end

	assign wcur = w_q[0];
	assign w_new = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) +
		RoundK[round_q] + wcur;
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_TAKE;
			fill_q <= '0;
			bits_q <= '0;
			round_q <= '0;
			ending_q <= 1'b0;
			closed_q <= 1'b0;
			padded_q <= 1'b0;
			tail_q <= 1'b0;
			widx_q <= '0;
			len_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
		end else begin
			if (put) begin
				w_q[fill_q[5:2]][8*(3-fill_q[1:0])+:8] <= put_byte;
				fill_q <= fill_q + 1'b1;
			end
			unique case (state_q)
				S_TAKE: begin
					if (q_valid) begin
						if (q_entry.is_byte) bits_q <= bits_q + 64'd8;
						if (q_entry.is_end) begin
							ending_q <= 1'b1;
							len_q <= bits_q + (q_entry.is_byte ? 64'd8 : 64'd0);
						end
						if (q_entry.is_byte && fill_q == 6'd63) state_q <= S_COMP;
						else if (q_entry.is_end) state_q <= S_PAD;
						if (q_entry.is_byte && fill_q == 6'd63) begin
							round_q <= '0;
							for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
						end
					end
				end
				S_PAD: begin
					padded_q <= 1'b1;
					if (!padded_q) tail_q <= (fill_q < LenPos);
					if (padded_q && tail_q && fill_q == 6'd63) closed_q <= 1'b1;
					if (fill_q == 6'd63) begin
						state_q <= S_COMP;
						round_q <= '0;
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					end
				end
				S_COMP: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= w_new;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					round_q <= round_q + 1'b1;
					if (round_q == 6'd63) state_q <= S_ADD;
				end
				S_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (closed_q) begin
						state_q <= S_OUT;
						widx_q <= '0;
					end else if (ending_q) begin
						state_q <= S_PAD;
						tail_q <= 1'b1;
					end else state_q <= S_TAKE;
				end
				S_OUT: begin
					if (out_ready) begin
						widx_q <= widx_q + 1'b1;
						if (widx_q == 2'd3) begin
							state_q <= S_TAKE;
							for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
							bits_q <= '0;
							ending_q <= 1'b0;
							closed_q <= 1'b0;
							padded_q <= 1'b0;
							tail_q <= 1'b0;
						end
					end
				end
				default: state_q <= S_TAKE;
			endcase
		end
	end

`include "assert_macros.svh"
	`ASSERT_IMPL(a_out_fill, clk, arst_n, state_q == S_OUT, fill_q == '0)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(widx_q))
	`ASSERT_IMPL(a_comp_nopop, clk, arst_n, state_q == S_COMP, !q_ready)
endmodule
